@@ rtl/ktmp_pkg.sv @@
// Package with the shared widths and the config reset value of the k-transaction profit core.
`timescale 1ns / 1ps

package ktmp_pkg;

  localparam int unsigned CFG_BITS = 4;
  localparam int unsigned OUT_BITS = 32;
  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(2);

endpackage : ktmp_pkg

@@ rtl/k_transaction_max_profit_dp_core.sv @@
// Top level of the k-transaction best-profit core, one price word per cycle unless stalled.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------
//  input    | in_valid_i / in_stall_o      | price_i, last_i
//  output   | out_valid_o / out_stall_i    | profit_o
//  config   | cfg_valid_i / cfg_ready_o    | max_transactions_i
//
// One word is taken per cycle unless in_stall_o is high; profit_o is a registered output.
// All transaction counts update together in the single stage behind the input register.
// The input stalls only when a last word waits on a full, stalled output register.
// Reset clears the input and output valids and all profit state; the limit resets to 2.
`timescale 1ns / 1ps

module k_transaction_max_profit_dp_core
  import ktmp_pkg::*;
#(
  parameter int unsigned MAX_TRANS   = 8,
  parameter int unsigned PRICE_BITS  = 16,
  parameter int unsigned PROFIT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PRICE_BITS-1:0] price_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OUT_BITS-1:0]   profit_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_BITS-1:0]   max_transactions_i
);

  localparam int unsigned WIDE_BITS =
      ((PROFIT_BITS > PRICE_BITS) ? PROFIT_BITS : PRICE_BITS) + 3;
  localparam int unsigned SEL_BITS =
      ((PROFIT_BITS > OUT_BITS) ? PROFIT_BITS : OUT_BITS) + 1;
  localparam logic signed [WIDE_BITS-1:0] PROFIT_MAX_W =
      {{(WIDE_BITS-PROFIT_BITS){1'b0}}, {PROFIT_BITS{1'b1}}};
  localparam logic [SEL_BITS-1:0] OUT_MAX_S =
      {{(SEL_BITS-OUT_BITS){1'b0}}, {OUT_BITS{1'b1}}};

  logic                   s1_valid_q;
  logic [PRICE_BITS-1:0]  s1_price_q;
  logic                   s1_last_q;
  logic                   s1_adv;
  logic                   out_free;

  logic [CFG_BITS-1:0]    max_trans_q;

  logic [PROFIT_BITS-1:0] total_q  [MAX_TRANS];
  logic [PROFIT_BITS-1:0] total_d  [MAX_TRANS];
  logic [PROFIT_BITS-1:0] ending_q [MAX_TRANS];
  logic [PROFIT_BITS-1:0] ending_d [MAX_TRANS];
  logic [PRICE_BITS-1:0]  prev_price_q;
  logic                   have_prev_q;

  logic                   out_valid_q;
  logic [OUT_BITS-1:0]    profit_q;
  logic [OUT_BITS-1:0]    profit_d;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign profit_o    = profit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_price_q <= price_i;
      s1_last_q  <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_trans_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_trans_q <= max_transactions_i;
    end
  end

  always_comb begin
    logic signed [WIDE_BITS-1:0] diff;
    logic signed [WIDE_BITS-1:0] gain;
    logic signed [WIDE_BITS-1:0] below;
    logic signed [WIDE_BITS-1:0] open_new;
    logic signed [WIDE_BITS-1:0] extend;
    logic signed [WIDE_BITS-1:0] best;
    diff = $signed({{(WIDE_BITS-PRICE_BITS){1'b0}}, s1_price_q})
         - $signed({{(WIDE_BITS-PRICE_BITS){1'b0}}, prev_price_q});
    gain = (diff > 0) ? diff : '0;
    for (int j = 0; j < MAX_TRANS; j++) begin
      if (j == 0) begin
        below = '0;
      end else begin
        below = $signed({{(WIDE_BITS-PROFIT_BITS){1'b0}}, total_q[j-1]});
      end
      open_new = below + gain;
      extend   = $signed({{(WIDE_BITS-PROFIT_BITS){1'b0}}, ending_q[j]}) + diff;
      best     = (open_new > extend) ? open_new : extend;
      if (!have_prev_q) begin
        ending_d[j] = ending_q[j];
      end else if (best <= 0) begin
        ending_d[j] = '0;
      end else if (best > PROFIT_MAX_W) begin
        ending_d[j] = {PROFIT_BITS{1'b1}};
      end else begin
        ending_d[j] = best[PROFIT_BITS-1:0];
      end
      total_d[j] = (ending_d[j] > total_q[j]) ? ending_d[j] : total_q[j];
    end
  end

  always_comb begin
    logic [PROFIT_BITS-1:0] sel;
    logic [SEL_BITS-1:0]    sel_ext;
    sel = '0;
    for (int j = 0; j < MAX_TRANS; j++) begin
      if ({{(32-CFG_BITS){1'b0}}, max_trans_q} == 32'(j + 1)) begin
        sel = total_d[j];
      end
    end
    if ({{(32-CFG_BITS){1'b0}}, max_trans_q} > 32'(MAX_TRANS)) begin
      sel = total_d[MAX_TRANS-1];
    end
    sel_ext  = {{(SEL_BITS-PROFIT_BITS){1'b0}}, sel};
    profit_d = (sel_ext > OUT_MAX_S) ? {OUT_BITS{1'b1}} : sel_ext[OUT_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_TRANS; j++) begin
        total_q[j]  <= '0;
        ending_q[j] <= '0;
      end
      prev_price_q <= '0;
      have_prev_q  <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        for (int j = 0; j < MAX_TRANS; j++) begin
          total_q[j]  <= '0;
          ending_q[j] <= '0;
        end
        prev_price_q <= '0;
        have_prev_q  <= 1'b0;
      end else begin
        total_q      <= total_d;
        ending_q     <= ending_d;
        prev_price_q <= s1_price_q;
        have_prev_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      profit_q <= profit_d;
    end
  end

`ifndef SYNTHESIS
  a_last_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> out_valid_q)
    else $error("A finished series did not load the output register.");

  a_last_clears_series: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> !have_prev_q && total_q[0] == '0)
    else $error("Series state was not cleared after the last word.");

  a_total_covers_ending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q[0] >= ending_q[0])
    else $error("Best total fell below the best profit ending today.");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q && out_valid_q)
    else $error("Input stalled without a last word blocked on the output.");
`endif

endmodule : k_transaction_max_profit_dp_core
